// ===== rtl/core/oate_pkg.sv =====
// Shared types, field widths and codes of the ordered array table engine.
package oate_pkg;

  // Fixed widths of the transaction fields.
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;

  // Width that holds any index or count for every supported depth.
  localparam int PTR_W  = 11;
  // Widest supported word.
  localparam int MAX_DW = 64;

  // The hit scanner looks at this many cells per cycle.
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  // Operation codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             write;
    logic             mark_en;
    logic             by_pos;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] count;
  } cell_ctrl_t;

  // Status of the hit scanner toward the sequencer.
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [PTR_W-1:0] index;
  } scan_res_t;

  // One result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [FOUND_W-1:0]        found;
    logic signed [VALUE_W-1:0] data;
    logic [COUNT_W-1:0]        count;
  } result_t;

endpackage

// ===== rtl/core/oate_cell.sv =====
// One storage cell of the element chain with its own shift, write and compare logic.
module oate_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  oate_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]  key,
  input  logic [DATA_WIDTH-1:0]  left_word,
  input  logic [DATA_WIDTH-1:0]  right_word,
  output logic [DATA_WIDTH-1:0]  word,
  output logic                   hit
);

  localparam logic [oate_pkg::PTR_W-1:0] IDX = oate_pkg::PTR_W'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up && (IDX > ctrl.pos)) begin
      word <= left_word;
    end else if ((ctrl.shift_up || ctrl.write) && (IDX == ctrl.pos)) begin
      word <= key;
    end else if (ctrl.shift_down && (IDX >= ctrl.pos)) begin
      word <= right_word;
    end
  end

  // The hit flag marks either the addressed cell or a live cell that holds the key.
  always_ff @(posedge clk) begin
    if (ctrl.mark_en) begin
      hit <= ctrl.by_pos ? (IDX == ctrl.pos) : ((word == key) && (IDX < ctrl.count));
    end
  end

endmodule

// ===== rtl/core/oate_scan.sv =====
// Hit scanner that walks the cell chain a group of lanes per cycle for the first hit.
module oate_scan #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DEPTH-1:0]      hits,
  input  logic [DATA_WIDTH-1:0] words [DEPTH],
  output oate_pkg::scan_res_t   res,
  output logic [DATA_WIDTH-1:0] hit_word
);

  localparam int NCH_RAW = (DEPTH + oate_pkg::LANES - 1) / oate_pkg::LANES;
  localparam int CHW     = (NCH_RAW > 1) ? $clog2(NCH_RAW) : 1;
  localparam int NPAD    = (1 << CHW) * oate_pkg::LANES;
  localparam logic [CHW-1:0] LASTCH = CHW'((DEPTH - 1) / oate_pkg::LANES);

  logic                  busy;
  logic [CHW-1:0]        chunk;
  logic [NPAD-1:0]       hit_pad;
  logic [DATA_WIDTH-1:0] word_pad [NPAD];
  logic                  any;
  logic [oate_pkg::LANE_W-1:0] lane;
  logic [DATA_WIDTH-1:0] group_word;

  assign hit_pad = NPAD'(hits);

  for (genvar i = 0; i < NPAD; i++) begin : g_pad
    if (i < DEPTH) begin : g_real
      assign word_pad[i] = words[i];
    end else begin : g_fill
      assign word_pad[i] = '0;
    end
  end

  // Lowest hit within the current group, and the OR of the hit words there.
  always_comb begin
    any        = 1'b0;
    lane       = '0;
    group_word = '0;
    for (int l = oate_pkg::LANES - 1; l >= 0; l--) begin
      if (hit_pad[{chunk, oate_pkg::LANE_W'(l)}]) begin
        any        = 1'b1;
        lane       = oate_pkg::LANE_W'(l);
        group_word = group_word | word_pad[{chunk, oate_pkg::LANE_W'(l)}];
      end
    end
  end

  assign res.done  = busy && (any || (chunk == LASTCH));
  assign res.hit   = any;
  assign res.index = oate_pkg::PTR_W'({chunk, lane});
  assign hit_word  = group_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      chunk <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      chunk <= '0;
    end else if (res.done) begin
      busy <= 1'b0;
    end else if (busy) begin
      chunk <= chunk + CHW'(1);
    end
  end

endmodule

// ===== rtl/core/ordered_array_table_engine.sv =====
// Top level of the ordered array table engine: cell chain, hit scanner and sequencer.
//
// The engine keeps a packed array of DEPTH signed words in a chain of cells, together with
// the element count, and runs one operation per input transaction, returning exactly one
// result transaction for each. Insert shifts every cell above the position up by one, all
// cells together, so an insert, an operation with a bad position, an insert into a full
// store and an unused mode all finish without a scan. Search, read, update and delete
// first let every cell mark itself in parallel (a key match for search, the addressed cell
// otherwise) and then walk the hit flags with an eight-lane scanner, one group of eight
// cells per cycle, stopping at the first hit; delete then shifts the upper cells down and
// update writes the addressed cell in the cycle the scan ends. Such an operation at position
// p ends at the group that holds p, a search that hits ends at the group of its first hit,
// and a search that misses walks every group. A new transaction is taken only once the
// previous operation has finished, but the block does not wait for the previous result
// to be taken: an output register holds it and one more finished result can park in a
// holding register, which passes it on to the output register when that frees. Stored
// words are DATA_WIDTH bits; the input value is sign extended or cut to that width, and
// data_out shows the low 32 bits of the stored pattern. Words that were never written hold
// no defined value, but only entries below the count are ever returned.
module ordered_array_table_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [oate_pkg::MODE_W-1:0]           mode,
  input  logic [oate_pkg::POS_W-1:0]            position,
  input  logic signed [oate_pkg::VALUE_W-1:0]   value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [oate_pkg::STATUS_W-1:0]         status,
  output logic [oate_pkg::FOUND_W-1:0]          found_index,
  output logic signed [oate_pkg::VALUE_W-1:0]   data_out,
  output logic [oate_pkg::COUNT_W-1:0]          element_count
);

  localparam int CNTW = $clog2(DEPTH + 1);

  // Sequencer and count state.
  oate_pkg::state_t          state;
  logic [CNTW-1:0]           count;

  // The operation under way while the scanner runs.
  logic [oate_pkg::MODE_W-1:0] op_mode;
  logic [oate_pkg::PTR_W-1:0]  op_pos;
  logic [DATA_WIDTH-1:0]       op_word;

  // Output register and the holding register behind it.
  oate_pkg::result_t         res;
  oate_pkg::result_t         pend;

  // Chain and scanner connections.
  oate_pkg::cell_ctrl_t      ctrl;
  logic [DATA_WIDTH-1:0]     key;
  logic [DATA_WIDTH-1:0]     cell_word [DEPTH];
  logic [DEPTH-1:0]          cell_hit;
  oate_pkg::scan_res_t       scan;
  logic [DATA_WIDTH-1:0]     scan_word;

  logic                         accept;
  logic signed [oate_pkg::MAX_DW-1:0] value_x;
  logic [DATA_WIDTH-1:0]        in_word;
  logic [oate_pkg::PTR_W-1:0]   pos_x;
  logic [oate_pkg::PTR_W-1:0]   cnt_x;
  logic [oate_pkg::PTR_W-1:0]   cnt_up_x;
  logic [oate_pkg::PTR_W-1:0]   cnt_dn_x;
  logic [oate_pkg::MAX_DW-1:0]  scan_word_x;
  logic                         go_scan;
  logic                         ins_do;
  oate_pkg::result_t            acc_res;
  oate_pkg::result_t            done_res;
  logic                         fin;
  logic                         out_free;
  logic                         out_load;
  logic                         pend_load;
  oate_pkg::result_t            fin_res;

  // A new operation is taken only when the previous one has fully finished.
  assign item_stall = (state != oate_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;

  assign value_x     = oate_pkg::MAX_DW'(value);
  assign in_word     = value_x[DATA_WIDTH-1:0];
  assign pos_x       = oate_pkg::PTR_W'(position);
  assign cnt_x       = oate_pkg::PTR_W'(count);
  assign cnt_up_x    = oate_pkg::PTR_W'(count + CNTW'(1));
  assign cnt_dn_x    = oate_pkg::PTR_W'(count - CNTW'(1));
  assign scan_word_x = oate_pkg::MAX_DW'(scan_word);

  // Decode of the incoming transaction: checks and the result of operations that need no scan.
  always_comb begin
    go_scan        = 1'b0;
    ins_do         = 1'b0;
    acc_res.status = oate_pkg::ST_OK;
    acc_res.found  = '0;
    acc_res.data   = '0;
    acc_res.count  = cnt_x[oate_pkg::COUNT_W-1:0];
    case (mode)
      oate_pkg::MODE_INSERT: begin
        if (pos_x > cnt_x) begin
          acc_res.status = oate_pkg::ST_INVALID;
        end else if (cnt_x == oate_pkg::PTR_W'(DEPTH)) begin
          acc_res.status = oate_pkg::ST_FULL;
        end else begin
          ins_do        = 1'b1;
          acc_res.count = cnt_up_x[oate_pkg::COUNT_W-1:0];
        end
      end
      oate_pkg::MODE_DELETE, oate_pkg::MODE_UPDATE, oate_pkg::MODE_READ: begin
        if (pos_x >= cnt_x) begin
          acc_res.status = oate_pkg::ST_INVALID;
        end else begin
          go_scan = 1'b1;
        end
      end
      oate_pkg::MODE_SEARCH: begin
        go_scan = 1'b1;
      end
      default: begin
        // Unused modes leave everything alone and report success.
      end
    endcase
  end

  // Result of an operation whose scan has just ended.
  always_comb begin
    done_res.status = oate_pkg::ST_OK;
    done_res.found  = '0;
    done_res.data   = scan_word_x[oate_pkg::VALUE_W-1:0];
    done_res.count  = cnt_x[oate_pkg::COUNT_W-1:0];
    if (op_mode == oate_pkg::MODE_SEARCH) begin
      done_res.data = '0;
      if (scan.hit) begin
        done_res.found = scan.index[oate_pkg::FOUND_W-1:0];
      end else begin
        done_res.status = oate_pkg::ST_NOTFOUND;
      end
    end else if (op_mode == oate_pkg::MODE_DELETE) begin
      done_res.count = cnt_dn_x[oate_pkg::COUNT_W-1:0];
    end
  end

  // Command for the chain: inserts and marking at acceptance, delete and update at scan end.
  always_comb begin
    ctrl       = '0;
    ctrl.pos   = pos_x;
    ctrl.count = cnt_x;
    key        = in_word;
    if (accept) begin
      ctrl.shift_up = ins_do;
      ctrl.mark_en  = go_scan;
      ctrl.by_pos   = (mode != oate_pkg::MODE_SEARCH);
    end else if ((state == oate_pkg::S_SCAN) && scan.done) begin
      ctrl.pos        = op_pos;
      key             = op_word;
      ctrl.shift_down = (op_mode == oate_pkg::MODE_DELETE);
      ctrl.write      = (op_mode == oate_pkg::MODE_UPDATE);
    end
  end

  // The output register frees up when it is empty or its transaction completes this cycle.
  assign out_free  = !result_valid || !result_stall;
  assign fin       = (accept && !go_scan) || ((state == oate_pkg::S_SCAN) && scan.done);
  assign fin_res   = (state == oate_pkg::S_SCAN) ? done_res : acc_res;
  assign out_load  = out_free && (fin || (state == oate_pkg::S_WAIT));
  assign pend_load = fin && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= oate_pkg::S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        oate_pkg::S_IDLE: begin
          if (accept) begin
            if (ins_do) begin
              count <= count + CNTW'(1);
            end
            if (go_scan) begin
              state <= oate_pkg::S_SCAN;
            end else if (!out_free) begin
              state <= oate_pkg::S_WAIT;
            end
          end
        end
        oate_pkg::S_SCAN: begin
          if (scan.done) begin
            if (op_mode == oate_pkg::MODE_DELETE) begin
              count <= count - CNTW'(1);
            end
            state <= out_free ? oate_pkg::S_IDLE : oate_pkg::S_WAIT;
          end
        end
        oate_pkg::S_WAIT: begin
          if (out_free) begin
            state <= oate_pkg::S_IDLE;
          end
        end
        default: begin
          state <= oate_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= mode;
      op_pos  <= pos_x;
      op_word <= in_word;
    end
    if (pend_load) begin
      pend <= fin_res;
    end
    if (out_load) begin
      res <= (state == oate_pkg::S_WAIT) ? pend : fin_res;
    end
  end

  assign status        = res.status;
  assign found_index   = res.found;
  assign data_out      = res.data;
  assign element_count = res.count;

  // The chain of cells; the end cells see zero beyond the array.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_left
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_right
      assign right_word = cell_word[i+1];
    end

    oate_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (key),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[i]),
      .hit        (cell_hit[i])
    );
  end

  oate_scan #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && go_scan),
    .hits     (cell_hit),
    .words    (cell_word),
    .res      (scan),
    .hit_word (scan_word)
  );

endmodule

// ===== rtl/core/oate_checker.sv =====
// Port-level checker of the ordered array table engine and its bind to the top level.
module oate_checker #(
  parameter int DEPTH = 64
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic [oate_pkg::STATUS_W-1:0]       status,
  input logic [oate_pkg::FOUND_W-1:0]        found_index,
  input logic signed [oate_pkg::VALUE_W-1:0] data_out,
  input logic [oate_pkg::COUNT_W-1:0]        element_count
);

  // A stalled result transaction stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  // A full store is only reported when the count sits at the depth.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == oate_pkg::ST_FULL) |->
      (element_count == oate_pkg::COUNT_W'(DEPTH)))
    else $error("store full reported below the depth");

  // Failed operations carry neither an index nor data.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != oate_pkg::ST_OK) |-> (found_index == '0) && (data_out == '0))
    else $error("failed operation returned index or data");

  // Reset leaves no result transaction on offer and the input open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("result offered or input stalled right after reset");

  // A transaction taken while the output is blocked fills the block, so the input stalls.
  a_park_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && result_valid && result_stall |=> item_stall)
    else $error("input open while a finished result is parked");

endmodule

bind ordered_array_table_engine oate_checker #(
  .DEPTH (DEPTH)
) u_oate_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .status        (status),
  .found_index   (found_index),
  .data_out      (data_out),
  .element_count (element_count)
);
